// ----- rtl/pipc_pkg.sv -----
// ----------------------------------------------------------------------------
// pipc_pkg
// Shared constants, types and state encoding for the point-in-polygon
// crossing-number core.
// ----------------------------------------------------------------------------
package pipc_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int COORD_BITS   = 24;
    localparam int COUNT_BITS   = 9;

    localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
    localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
    localparam int VERT_BITS    = 2 * COORD_BITS;
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int PROD_BITS    = 2 * DIFF_BITS;

    // Length of the S_DRAIN wait after the closing-edge command, until the crossing count settles
    localparam int DRAIN_CYCLES = 3;
    localparam int DRAIN_BITS   = $clog2(DRAIN_CYCLES);

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CLOSE,
        S_DRAIN,
        S_DONE
    } pipc_state_t;

    typedef struct packed {
        logic                 load_en;
        logic                 query_start;
        logic                 rd_en;
        logic                 rd_first;
        logic [ADDR_BITS-1:0] rd_addr;
        logic                 close_edge;
        logic                 result_load;
    } pipc_cmd_t;

    typedef struct packed {
        logic [CNT_BITS-1:0] vert_count;
        logic                out_busy;
    } pipc_status_t;

endpackage

// ----- rtl/pipc_ram.sv -----
// ----------------------------------------------------------------------------
// pipc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pipc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/pipc_ctrl.sv -----
// ----------------------------------------------------------------------------
// pipc_ctrl
// Sequencer: takes transfers, walks the vertex store for a query, drains the
// edge pipeline and hands the result to the output register.
// ----------------------------------------------------------------------------
module pipc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   req_type,
    input  pipc_pkg::pipc_status_t status,
    output logic                   in_stall,
    output pipc_pkg::pipc_cmd_t    cmd
);
    import pipc_pkg::*;

    pipc_state_t          state_reg, state_next;
    logic [CNT_BITS-1:0]  idx_reg, idx_next;
    logic [DRAIN_BITS-1:0] drain_reg, drain_next;
    logic                 accept;
    logic                 last_read;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign last_read = ((idx_reg + CNT_BITS'(1)) == status.vert_count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            drain_reg <= drain_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        drain_next = drain_reg;
        cmd        = '0;
        cmd.rd_addr = idx_reg[ADDR_BITS-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req_type == REQ_LOAD))
                begin
                    cmd.load_en = 1'b1;
                end
                else if (accept)
                begin
                    cmd.query_start = 1'b1;
                    idx_next        = '0;
                    // Empty polygon: no edges to walk
                    state_next = (status.vert_count == '0) ? S_DONE : S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_first = (idx_reg == '0);
                idx_next     = idx_reg + CNT_BITS'(1);
                if (last_read)
                begin
                    state_next = S_CLOSE;
                end
            end
            S_CLOSE:
            begin
                cmd.close_edge = 1'b1;
                drain_next     = '0;
                state_next     = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (drain_reg == DRAIN_BITS'(DRAIN_CYCLES - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    drain_next = drain_reg + DRAIN_BITS'(1);
                end
            end
            S_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The closing edge always follows the read of the last vertex
    a_close_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.close_edge |-> $past(cmd.rd_en))
        else $error("closing edge without a preceding vertex read");

    // Never overwrite a result the consumer has not taken
    a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |-> !status.out_busy)
        else $error("result loaded while output register is stalled");

    // A query walk never overlaps a store write
    a_no_load_during_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> !cmd.load_en && !accept)
        else $error("load or transfer taken during a query walk");

endmodule

// ----- rtl/pipc_dp.sv -----
// ----------------------------------------------------------------------------
// pipc_dp
// Datapath: vertex store, edge pipeline (difference, cross product, compare),
// crossing counter and output register.
// ----------------------------------------------------------------------------
module pipc_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pipc_pkg::pipc_cmd_t                   cmd,
    input  logic                                  start_new,
    input  logic signed [pipc_pkg::COORD_BITS-1:0] coord_x,
    input  logic signed [pipc_pkg::COORD_BITS-1:0] coord_y,
    input  logic                                  out_stall,
    output pipc_pkg::pipc_status_t                status,
    output logic                                  out_valid,
    output logic                                  inside_res,
    output logic [pipc_pkg::COUNT_BITS-1:0]       crossing_count,
    output logic                                  load_overflow
);
    import pipc_pkg::*;

    // Vertex store and load bookkeeping
    logic [CNT_BITS-1:0]  vert_count_reg;
    logic                 ovf_reg;
    logic                 store_full;
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [VERT_BITS-1:0] rdata;

    // Query point
    logic signed [COORD_BITS-1:0] px_reg, py_reg;

    // Read return alignment
    logic                 rd_v_reg, rd_first_reg, close_d_reg;
    logic [VERT_BITS-1:0] prev_reg, first_reg;

    // Edge stage inputs
    logic                         e_v;
    logic [VERT_BITS-1:0]         v2;
    logic signed [COORD_BITS-1:0] x1, y1, x2, y2, lo, hi;
    logic                         e_skip;

    // Stage 1: differences
    logic                        s1_v_reg, s1_skip_reg, s1_neg_reg;
    logic signed [DIFF_BITS-1:0] ey_reg, dx_reg, ex_reg, dy_reg;

    // Stage 2: products
    logic                        s2_v_reg, s2_skip_reg, s2_neg_reg;
    logic signed [PROD_BITS-1:0] p1_reg, p2_reg;
    logic                        hit;

    logic [CNT_BITS-1:0] count_reg;
    logic                out_valid_reg;

    assign store_full = (vert_count_reg == CNT_BITS'(MAX_VERTICES));
    assign wr_en      = cmd.load_en && (start_new || !store_full);
    assign wr_addr    = start_new ? '0 : vert_count_reg[ADDR_BITS-1:0];

    pipc_ram #(
        .WIDTH (VERT_BITS),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata ({coord_x, coord_y}),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_addr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vert_count_reg <= '0;
            ovf_reg        <= 1'b0;
        end
        else if (cmd.load_en)
        begin
            if (start_new)
            begin
                vert_count_reg <= CNT_BITS'(1);
                ovf_reg        <= 1'b0;
            end
            else if (store_full)
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                vert_count_reg <= vert_count_reg + CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        if (rd_v_reg)
        begin
            prev_reg <= rdata;
            if (rd_first_reg)
            begin
                first_reg <= rdata;
            end
        end
    end

    // Edge from the previous vertex to the current one, or closing edge
    assign e_v    = (rd_v_reg && !rd_first_reg) || close_d_reg;
    assign v2     = close_d_reg ? first_reg : rdata;
    assign x1     = prev_reg[VERT_BITS-1:COORD_BITS];
    assign y1     = prev_reg[COORD_BITS-1:0];
    assign x2     = v2[VERT_BITS-1:COORD_BITS];
    assign y2     = v2[COORD_BITS-1:0];
    assign lo     = (y1 < y2) ? y1 : y2;
    assign hi     = (y1 < y2) ? y2 : y1;
    // Horizontal edges and spans missing the ray are dropped
    assign e_skip = (y1 == y2) || (py_reg < lo) || (py_reg >= hi);

    always_ff @(posedge clk)
    begin
        s1_skip_reg <= e_skip;
        s1_neg_reg  <= (y2 < y1);
        ey_reg      <= DIFF_BITS'(py_reg) - DIFF_BITS'(y1);
        dx_reg      <= DIFF_BITS'(x2) - DIFF_BITS'(x1);
        ex_reg      <= DIFF_BITS'(px_reg) - DIFF_BITS'(x1);
        dy_reg      <= DIFF_BITS'(y2) - DIFF_BITS'(y1);

        s2_skip_reg <= s1_skip_reg;
        s2_neg_reg  <= s1_neg_reg;
        p1_reg      <= PROD_BITS'(ey_reg) * PROD_BITS'(dx_reg);
        p2_reg      <= PROD_BITS'(ex_reg) * PROD_BITS'(dy_reg);
    end

    // Crossing right of the point, with the comparison flipped for falling edges
    assign hit = s2_v_reg && !s2_skip_reg &&
                 (s2_neg_reg ? (p1_reg < p2_reg) : (p1_reg > p2_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg      <= 1'b0;
            rd_first_reg  <= 1'b0;
            close_d_reg   <= 1'b0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg     <= cmd.rd_en;
            rd_first_reg <= cmd.rd_first;
            close_d_reg  <= cmd.close_edge;
            s1_v_reg     <= e_v;
            s2_v_reg     <= s1_v_reg;
            if (cmd.query_start)
            begin
                count_reg <= '0;
            end
            else if (hit)
            begin
                count_reg <= count_reg + CNT_BITS'(1);
            end
            if (cmd.result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            inside_res     <= count_reg[0];
            crossing_count <= COUNT_BITS'(count_reg);
            load_overflow  <= ovf_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status.vert_count = vert_count_reg;
    assign status.out_busy   = out_valid_reg && out_stall;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        vert_count_reg <= CNT_BITS'(MAX_VERTICES))
        else $error("vertex count beyond store depth");

    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.result_load))
        else $error("output valid raised without a result load");

    a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_valid_reg && out_stall) |-> out_valid_reg && $stable(crossing_count))
        else $error("stalled result dropped or changed");

endmodule

// ----- rtl/point_in_polygon_crossing_core.sv -----
// Timing: a load is written in the cycle it is taken; a query over n stored vertices
//   does one vertex-store read per cycle, drains the edge pipeline (difference, product)
//   and hands off its result once the output register is free (an empty polygon skips to
//   the hand-off). No transfer is taken meanwhile; loads go every cycle while idle.
// Reset: asynchronous, active low; empties the polygon and clears the overflow flag.
//   Store contents stay undefined until written.
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_core
// Ray-casting point-in-polygon test: loads polygon vertices into a store and
// answers test-point queries with the crossing count and inside parity.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Request channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  req_type,
    input  logic                                  start_new,
    input  logic signed [pipc_pkg::COORD_BITS-1:0] coord_x,
    input  logic signed [pipc_pkg::COORD_BITS-1:0] coord_y,
    // Result channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  inside_res,
    output logic [pipc_pkg::COUNT_BITS-1:0]       crossing_count,
    output logic                                  load_overflow
);
    import pipc_pkg::*;

    // Command and status between sequencer and datapath
    pipc_cmd_t    cmd;
    pipc_status_t status;

    // Sequencer: accept transfers only while idle. A load is written to the
    // store in the cycle it is taken; a query walks vertices 0..n-1, one read
    // per cycle, then injects the closing edge back to vertex 0 and waits for
    // the edge pipeline to settle before handing the count off.
    pipc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // Datapath: each edge is tested exactly by comparing the cross products
    // (py-y1)*(x2-x1) and (px-x1)*dy, flipping the comparison when dy < 0,
    // so no division is needed. The output register holds a finished result
    // while the consumer stalls; a new result waits until it is taken.
    pipc_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .start_new      (start_new),
        .coord_x        (coord_x),
        .coord_y        (coord_y),
        .out_stall      (out_stall),
        .status         (status),
        .out_valid      (out_valid),
        .inside_res     (inside_res),
        .crossing_count (crossing_count),
        .load_overflow  (load_overflow)
    );

endmodule
